>>> rtl/core/elt_pkg.sv
// Shared types and constants for the exclusive node lock table.
`default_nettype none

package elt_pkg;

    localparam int NUM_NODES  = 128;
    localparam int NODE_W     = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int CLIENT_W   = 32;
    localparam int NODE_ID_W  = 7;
    localparam int REQ_W      = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REL_NODE   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REL_CLIENT = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [NODE_W-1:0]   node_idx;
        logic                node_ok;
        logic [CLIENT_W-1:0] client_id;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_EXEC = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/elt_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module elt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/elt_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
`default_nettype none

module elt_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [elt_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output elt_pkg::req_t                            q_data
);

    import elt_pkg::*;

    req_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    req_t              in_req;
    logic [NODE_ID_W-1:0] node_id;
    logic              push, pop;

    assign node_id = s_tdata[2 +: NODE_ID_W];

    always_comb begin
        in_req.req_type  = s_tdata[0 +: REQ_W];
        in_req.node_idx  = NODE_W'(node_id);
        in_req.node_ok   = (9'(node_id) < 9'(NUM_NODES));
        in_req.client_id = s_tdata[2 + NODE_ID_W +: CLIENT_W];
    end

    assign s_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = q_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_req;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/elt_back.sv
// Back end: scans the owner table for the client, applies the request and registers the result.
`default_nettype none

module elt_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire elt_pkg::req_t                 q_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [elt_pkg::M_TDATA_W-1:0]      m_tdata
);

    import elt_pkg::*;

    back_state_t          state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [NODE_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [NODE_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [NODE_W-1:0]    fidx_reg, fidx_next;
    logic [CLIENT_W-1:0]  nowner_reg, nowner_next;
    logic [NUM_NODES-1:0] valid_reg, valid_next;
    logic                 out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                 ram_we;
    logic [NODE_W-1:0]    ram_addr;
    logic [CLIENT_W-1:0]  ram_rdata;

    logic                 nvalid, acq_ok, granted, locked, has;
    logic [CLIENT_W-1:0]  holder, holder_out;
    logic [NODE_W-1:0]    cn, cn_out;

    elt_ram #(
        .WIDTH (CLIENT_W),
        .DEPTH (NUM_NODES)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cur_reg.client_id),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        nvalid     = cur_reg.node_ok && valid_reg[cur_reg.node_idx];
        acq_ok     = cur_reg.node_ok && !(nvalid && (nowner_reg != cur_reg.client_id));
        granted    = 1'b0;
        locked     = nvalid;
        holder     = nowner_reg;
        has        = found_reg;
        cn         = fidx_reg;
        valid_next = valid_reg;
        unique case (cur_reg.req_type)
            REQ_QUERY: begin
            end
            REQ_ACQUIRE: begin
                if (acq_ok) begin
                    if (found_reg) begin
                        valid_next[fidx_reg] = 1'b0;
                    end
                    valid_next[cur_reg.node_idx] = 1'b1;
                    granted = 1'b1;
                    locked  = 1'b1;
                    holder  = cur_reg.client_id;
                    has     = 1'b1;
                    cn      = cur_reg.node_idx;
                end
            end
            REQ_REL_NODE: begin
                if (cur_reg.node_ok) begin
                    valid_next[cur_reg.node_idx] = 1'b0;
                end
                locked = 1'b0;
                has    = found_reg && !(cur_reg.node_ok && (fidx_reg == cur_reg.node_idx));
            end
            REQ_REL_CLIENT: begin
                if (found_reg) begin
                    valid_next[fidx_reg] = 1'b0;
                end
                locked = nvalid && !(found_reg && (fidx_reg == cur_reg.node_idx));
                has    = 1'b0;
            end
            default: begin
            end
        endcase
        holder_out = locked ? holder : '0;
        cn_out     = has ? cn : '0;
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        nowner_next   = nowner_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        q_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = scan_idx_reg;

        if (cmp_vld_reg) begin
            if (valid_reg[cmp_idx_reg] && (ram_rdata == cur_reg.client_id) && !found_reg) begin
                found_next = 1'b1;
                fidx_next  = cmp_idx_reg;
            end
            if (cmp_idx_reg == cur_reg.node_idx) begin
                nowner_next = ram_rdata;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next      = q_data;
                    found_next    = 1'b0;
                    fidx_next     = '0;
                    nowner_next   = '0;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg == NODE_W'(NUM_NODES - 1)) begin
                    state_next = ST_WAIT;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!out_vld_reg || m_tready) begin
                    ram_addr     = cur_reg.node_idx;
                    ram_we       = (cur_reg.req_type == REQ_ACQUIRE) && acq_ok;
                    out_vld_next = 1'b1;
                    out_data_next = {5'd0, NODE_ID_W'(cn_out), has,
                                     locked && (holder == cur_reg.client_id),
                                     holder_out, locked, granted};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            if (state_reg == ST_EXEC && (!out_vld_reg || m_tready)) begin
                valid_reg <= valid_next;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        nowner_reg   <= nowner_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/exclusive_node_lock_table.sv
// Top level of the exclusive node lock table.
// Flow: an accepted request beat is queued, then the back end scans the owner RAM, one entry per
// cycle, and registers the result on m_tvalid once the output stage is free.
// Requests are taken one at a time, each after the last result is registered; two requests queue ahead of the scan.
// Reset: aresetn clears all lock valid bits, the queue and the output stage.
`default_nettype none

module exclusive_node_lock_table (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // req_type[1:0], node_id[8:2], client_id[40:9], zero fill above
    input  wire logic [elt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // granted[0], node_locked[1], node_holder[33:2], locked_by_this_client[34],
    // client_has_lock[35], client_node[42:36], zero fill above
    output logic [elt_pkg::M_TDATA_W-1:0]          m_tdata
);

    import elt_pkg::*;

    logic q_valid;
    logic q_ready;
    req_t q_data;

    elt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    elt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> dv/exclusive_node_lock_table_tb.sv
// Testbench for the exclusive node lock table: directed and random lock requests checked beat by beat.
`timescale 1ns / 1ps

module exclusive_node_lock_table_tb;
    import elt_pkg::*;

    localparam int LONG_HOLD  = 6 * (NUM_NODES + 3);
    localparam int IDLE_LIMIT = 4 * LONG_HOLD;
    localparam int REQ_BITS   = REQ_W + NODE_ID_W + CLIENT_W;

    typedef struct packed {
        logic                 granted;
        logic                 node_locked;
        logic [CLIENT_W-1:0]  node_holder;
        logic                 locked_by_this_client;
        logic                 client_has_lock;
        logic [NODE_ID_W-1:0] client_node;
    } lock_status_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    bit                   node_held [NUM_NODES];
    logic [CLIENT_W-1:0]  node_owner [NUM_NODES];
    lock_status_t         expected_status_q [$];
    logic [CLIENT_W-1:0]  client_pool [8];
    logic [NODE_ID_W-1:0] node_pool [6];

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int errors       = 0;
    int reqs_sent    = 0;
    int acquires     = 0;
    int grants       = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    exclusive_node_lock_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic bit find_client_lock(input logic [CLIENT_W-1:0] client, output int idx);
        idx = 0;
        for (int i = 0; i < NUM_NODES; i++) begin
            if (node_held[i] && node_owner[i] == client) begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic lock_status_t apply_request(input logic [REQ_W-1:0] req,
                                                   input logic [NODE_ID_W-1:0] node,
                                                   input logic [CLIENT_W-1:0] client);
        lock_status_t st;
        bit           in_range;
        int           held_idx;
        st       = '0;
        in_range = node < NUM_NODES;
        case (req)
            REQ_ACQUIRE: begin
                if (in_range && !(node_held[node] && node_owner[node] != client)) begin
                    if (find_client_lock(client, held_idx)) node_held[held_idx] = 1'b0;
                    node_held[node]  = 1'b1;
                    node_owner[node] = client;
                    st.granted       = 1'b1;
                end
            end
            REQ_REL_NODE: begin
                if (in_range) node_held[node] = 1'b0;
            end
            REQ_REL_CLIENT: begin
                if (find_client_lock(client, held_idx)) node_held[held_idx] = 1'b0;
            end
            default: ;
        endcase
        st.node_locked           = in_range && node_held[node];
        st.node_holder           = st.node_locked ? node_owner[node] : '0;
        st.locked_by_this_client = st.node_locked && st.node_holder == client;
        st.client_has_lock       = find_client_lock(client, held_idx);
        st.client_node           = st.client_has_lock ? held_idx[NODE_ID_W-1:0] : '0;
        return st;
    endfunction

    function automatic void check_field(input string field, input logic [CLIENT_W-1:0] want,
                                        input logic [CLIENT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endfunction

    function automatic void refresh_pools();
        client_pool[0] = '0;
        client_pool[1] = '1;
        for (int c = 2; c < 8; c++) client_pool[c] = $urandom();
        node_pool[0] = '0;
        node_pool[1] = '1;
        for (int n = 2; n < 6; n++) begin
            node_pool[n] = NODE_ID_W'($urandom_range((1 << NODE_ID_W) - 1, 0));
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat, with s_tvalid
    // still high so that a following beat can go out without a bubble.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [NODE_ID_W-1:0] node,
                                input logic [CLIENT_W-1:0] client);
        int           gap;
        lock_status_t st;
        gap = (idle_on && $urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - REQ_BITS){1'b0}}, client, node, req};
        do @(posedge aclk); while (!s_tready);
        st = apply_request(req, node, client);
        expected_status_q.push_back(st);
        reqs_sent++;
        if (req == REQ_ACQUIRE) acquires++;
        if (st.granted) grants++;
        @(negedge aclk);
    endtask

    task automatic send_random_request();
        int                   pick;
        logic [REQ_W-1:0]     req;
        logic [NODE_ID_W-1:0] node;
        logic [CLIENT_W-1:0]  client;
        pick = $urandom_range(9, 0);
        if (pick < 4)      req = REQ_ACQUIRE;
        else if (pick < 6) req = REQ_QUERY;
        else if (pick < 8) req = REQ_REL_NODE;
        else               req = REQ_REL_CLIENT;
        node   = ($urandom_range(4, 0) == 0)
                 ? NODE_ID_W'($urandom_range((1 << NODE_ID_W) - 1, 0))
                 : node_pool[$urandom_range(5, 0)];
        client = ($urandom_range(9, 0) == 0) ? $urandom() : client_pool[$urandom_range(7, 0)];
        send_request(req, node, client);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_status_q.size() != 0);
    endtask

    task automatic test_directed_cases();
        send_request(REQ_QUERY,      '0,        '0);
        send_request(REQ_ACQUIRE,    '0,        '0);
        send_request(REQ_QUERY,      '0,        '0);
        send_request(REQ_ACQUIRE,    '0,        '0);
        send_request(REQ_ACQUIRE,    '0,        '1);
        send_request(REQ_ACQUIRE,    '1,        '1);
        send_request(REQ_ACQUIRE,    '1,        '0);
        send_request(REQ_ACQUIRE,    7'd5,      '0);
        send_request(REQ_QUERY,      '0,        '0);
        send_request(REQ_REL_NODE,   '0,        '1);
        send_request(REQ_REL_NODE,   '1,        '0);
        send_request(REQ_QUERY,      '1,        '1);
        send_request(REQ_REL_CLIENT, 7'd5,      '0);
        send_request(REQ_REL_CLIENT, 7'd5,      '0);
        send_request(REQ_REL_CLIENT, 7'd9,      32'd12345);
        send_request(REQ_ACQUIRE,    '1,        32'h5555_5555);
        send_request(REQ_ACQUIRE,    7'h2A,     32'hAAAA_AAAA);
        send_request(REQ_QUERY,      '1,        32'hAAAA_AAAA);
        send_request(REQ_ACQUIRE,    '1,        32'hAAAA_AAAA);
        send_request(REQ_REL_NODE,   '1,        32'hAAAA_AAAA);
        send_request(REQ_ACQUIRE,    '1,        32'hAAAA_AAAA);
        send_request(REQ_QUERY,      7'h2A,     32'h5555_5555);
        send_request(REQ_REL_CLIENT, 7'h55,     32'hAAAA_AAAA);
        send_request(REQ_QUERY,      '1,        32'hAAAA_AAAA);
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            idle_on = (phase != 2);
            refresh_pools();
            for (int n = 0; n < 100; n++) send_random_request();
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        idle_on  = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 8; n++) send_random_request();
        drain_results();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        refresh_pools();
        for (int n = 0; n < 60; n++) send_random_request();
        drain_results();
    endtask

    initial begin : result_sink
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(4, 0) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(3, 1) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        lock_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_status_q.size() == 0) begin
                $error("Result beat 0x%0h arrived with no request outstanding", m_tdata);
                errors++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("granted",               want.granted,               m_tdata[0]);
                check_field("node_locked",           want.node_locked,           m_tdata[1]);
                check_field("node_holder",           want.node_holder,           m_tdata[33:2]);
                check_field("locked_by_this_client", want.locked_by_this_client, m_tdata[34]);
                check_field("client_has_lock",       want.client_has_lock,       m_tdata[35]);
                check_field("client_node",           want.client_node,           m_tdata[42:36]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_back_to_back();
        repeat (NUM_NODES + 8) @(posedge aclk);
        $display("Sent %0d lock requests (%0d acquires, %0d granted) and checked %0d results.",
                 reqs_sent, acquires, grants, results_seen);
        $display("Covered owner re-acquire, refused and moving acquires, idle releases, %s",
                 "a long output stall and back-to-back beats.");
        if (errors == 0 && expected_status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_status_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/elt_pkg.sv
rtl/core/elt_ram.sv
rtl/core/elt_front.sv
rtl/core/elt_back.sv
rtl/core/exclusive_node_lock_table.sv
dv/exclusive_node_lock_table_tb.sv
